FILE: rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

  localparam logic [7:0] WILDCARD = 8'h2E;
  localparam logic [7:0] NEWLINE  = 8'h0A;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [3:0] SEEN_MAX = 4'd15;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes (address bits [4:3]).
  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_IGNORE_CASE    = 2'd2;
  localparam logic [1:0] REG_WHOLE_WORD     = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_last;
  } lpm_in_t;

  typedef struct packed {
    logic        line_matched;
    logic [31:0] line_index;
    logic [31:0] matched_total;
  } lpm_out_t;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic        ignore_case;
    logic        whole_word;
  } lpm_cfg_t;

  // Per-cell compare results on the byte entering the cell.
  typedef struct packed {
    logic eq0;    // position ok for a match ending at the newest byte
    logic eq1;    // position ok for a match ending one byte back
    logic alnum;  // byte is ASCII alphanumeric
  } lpm_cell_st_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] pat_byte(input logic [63:0] pat, input logic [2:0] idx);
    return pat[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic byte_match(input logic [7:0] p, input logic [7:0] t,
                                      input logic fold_en);
    logic r;
    r = 1'b0;
    if (p == WILDCARD) begin
      r = (t != NEWLINE) && (t != NUL_BYTE);
    end else if (fold_en) begin
      r = (fold(p) == fold(t));
    end else begin
      r = (p == t);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lpm_cfg.sv
`default_nettype none

module lpm_cfg (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [lpm_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire  [lpm_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [lpm_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready,
  output lpm_pkg::lpm_cfg_t                   cfg
);

  lpm_pkg::lpm_cfg_t cfg_r;
  lpm_pkg::lpm_cfg_t cfg_nxt;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx    = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        lpm_pkg::REG_PATTERN_BYTES:  cfg_nxt.pattern_bytes  = cfg_pwdata;
        lpm_pkg::REG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_pwdata[3:0];
        lpm_pkg::REG_IGNORE_CASE:    cfg_nxt.ignore_case    = cfg_pwdata[0];
        lpm_pkg::REG_WHOLE_WORD:     cfg_nxt.whole_word     = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lpm_pkg::REG_PATTERN_BYTES:  cfg_prdata = cfg_r.pattern_bytes;
      lpm_pkg::REG_PATTERN_LENGTH: cfg_prdata = {60'd0, cfg_r.pattern_length};
      lpm_pkg::REG_IGNORE_CASE:    cfg_prdata = {63'd0, cfg_r.ignore_case};
      lpm_pkg::REG_WHOLE_WORD:     cfg_prdata = {63'd0, cfg_r.whole_word};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpm_cell.sv
`default_nettype none

// One window position: holds a byte, passes it on each accepted word and
// checks the byte it is receiving against its two candidate pattern bytes.
module lpm_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       shift_en,
  input  wire                       clear,
  input  wire  [7:0]                byte_in,
  input  wire  [7:0]                pat0,
  input  wire                       use0,
  input  wire  [7:0]                pat1,
  input  wire                       use1,
  input  wire                       ignore_case,
  output logic [7:0]                byte_q,
  output lpm_pkg::lpm_cell_st_t     st
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_q = byte_r;

  always_comb begin
    st.eq0   = !use0 || lpm_pkg::byte_match(pat0, byte_in, ignore_case);
    st.eq1   = !use1 || lpm_pkg::byte_match(pat1, byte_in, ignore_case);
    st.alnum = lpm_pkg::is_alnum(byte_in);
    byte_nxt = byte_r;
    if (shift_en) byte_nxt = clear ? 8'h00 : byte_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/line_pattern_matcher_core.sv
`default_nettype none

// Line pattern matcher: one text word per cycle, no stall on the input side
// while the output register is free or being drained.
// The line result is registered and shown in the cycle after its last word is accepted.
// Throughput: one word per cycle when not stalled; PATTERN_MAX+2 window cells.
// Reset (rst_n low, synchronous): window and counters clear, line number to one,
// configuration registers to zero, no result pending.
module line_pattern_matcher_core #(
  parameter int unsigned PATTERN_MAX = 8   // 1..8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // text words
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  lpm_pkg::lpm_in_t                    in_data,
  // line results
  output logic                                out_valid,
  input  wire                                 out_ready,
  output lpm_pkg::lpm_out_t                   out_data,
  // configuration
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [lpm_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire  [lpm_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [lpm_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned DEPTH = PATTERN_MAX + 2;
  localparam logic [3:0]  LEN_MAX = 4'(PATTERN_MAX);

  lpm_pkg::lpm_cfg_t cfg;

  lpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [3:0]          seen_r,  seen_nxt;
  logic                found_r, found_nxt;
  logic [31:0]         line_r,  line_nxt;
  logic [31:0]         count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  lpm_pkg::lpm_out_t   out_data_r,  out_data_nxt;

  logic                accept;
  logic [3:0]          len_c;      // effective pattern length
  logic [3:0]          seen_s;     // byte count including the incoming word

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign len_c  = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
  assign seen_s = (seen_r == lpm_pkg::SEEN_MAX) ? seen_r : seen_r + 4'd1;

  // ---------------------------------------------------------------------
  // Cell chain. Cell k sees the byte that lands at window position k.
  // For a match ending at position 0 it checks pattern byte len-1-k, for one
  // ending at position 1 it checks pattern byte len-k.
  // ---------------------------------------------------------------------
  logic [7:0]                 win   [DEPTH];
  lpm_pkg::lpm_cell_st_t      cst   [DEPTH];
  logic [DEPTH-1:0]           eq0_v, eq1_v, alnum_v;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [7:0] byte_in;
    logic [3:0] idx0, idx1;
    logic       use0, use1;

    if (k == 0) begin : g_head
      assign byte_in = in_data.text_byte;
    end else begin : g_link
      assign byte_in = win[k-1];
    end

    assign idx0 = len_c - 4'(k) - 4'd1;
    assign idx1 = len_c - 4'(k);
    assign use0 = 4'(k) < len_c;
    assign use1 = (k != 0) && (4'(k) <= len_c);

    lpm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (accept),
      .clear       (in_data.line_last),
      .byte_in     (byte_in),
      .pat0        (lpm_pkg::pat_byte(cfg.pattern_bytes, idx0[2:0])),
      .use0        (use0),
      .pat1        (lpm_pkg::pat_byte(cfg.pattern_bytes, idx1[2:0])),
      .use1        (use1),
      .ignore_case (cfg.ignore_case),
      .byte_q      (win[k]),
      .st          (cst[k])
    );

    assign eq0_v[k]   = cst[k].eq0;
    assign eq1_v[k]   = cst[k].eq1;
    assign alnum_v[k] = cst[k].alnum;
  end

  // ---------------------------------------------------------------------
  // Match decision. Window slots beyond the bytes of the line always hold
  // zero, which is not alphanumeric, so the left-neighbor checks need no
  // extra byte-count gate.
  // ---------------------------------------------------------------------
  logic left0, left1;   // alnum byte left of the candidate match
  logic hit0, hit1, line_hit;

  always_comb begin
    left0 = 1'b0;
    left1 = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (4'(k) == len_c)         left0 = left0 | alnum_v[k];
      if (4'(k) == len_c + 4'd1)  left1 = left1 | alnum_v[k];
    end
  end

  // match ending one byte back: its right neighbor is the incoming byte
  assign hit1 = (len_c != 4'd0) && ({1'b0, seen_s} >= {1'b0, len_c} + 5'd1) && (&eq1_v) &&
                (!cfg.whole_word || (!alnum_v[0] && !left1));
  // match ending at the last byte of the line: line edge on the right
  assign hit0 = (len_c != 4'd0) && (seen_s >= len_c) && (&eq0_v) &&
                (!cfg.whole_word || !left0);

  assign line_hit = found_r || hit1 || hit0;

  always_comb begin
    seen_nxt      = seen_r;
    found_nxt     = found_r;
    line_nxt      = line_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (accept) begin
      if (in_data.line_last) begin
        if (line_hit && count_r != lpm_pkg::COUNT_MAX) count_nxt = count_r + 32'd1;
        out_valid_nxt              = 1'b1;
        out_data_nxt.line_matched  = line_hit;
        out_data_nxt.line_index    = line_r;
        out_data_nxt.matched_total = count_nxt;
        if (line_r != lpm_pkg::COUNT_MAX) line_nxt = line_r + 32'd1;
        seen_nxt  = 4'd0;
        found_nxt = 1'b0;
      end else begin
        seen_nxt  = seen_s;
        found_nxt = found_r || hit1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 4'd0;
      found_r     <= 1'b0;
      line_r      <= 32'd1;
      count_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      found_r     <= found_nxt;
      line_r      <= line_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
